>>> design/base58_string_decoder_assert.svh
// Assertion macros shared by the base58 decoder RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BASE58_STRING_DECODER_ASSERT_SVH
`define BASE58_STRING_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define B58_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define B58_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/b58dec_pkg.sv
// Shared types, constants and the alphabet decode for the base58 decoder.
// No dependencies.
package b58dec_pkg;

  localparam int unsigned ACC_BYTES_DEF = 64;
  localparam int unsigned RESULT_CAP    = 64;
  localparam int unsigned ONES_MAX      = 127;
  localparam int unsigned RADIX         = 58;
  localparam logic [7:0]  ONE_CHAR      = 8'h31;
  localparam logic [6:0]  MAXLEN_RESET  = 7'd25;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_INVALID  = 2'd1,
    STAT_OVERFLOW = 2'd2,
    STAT_TOO_LONG = 2'd3
  } b58_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SCAN,
    ST_CHECK,
    ST_EMIT
  } b58_state_e;

  // Link between neighbor cells: a token plus its carry (or the digit at entry)
  typedef struct packed {
    logic       valid;
    logic [5:0] carry;
  } b58_lnk_t;

  // Broadcast controls to every cell
  typedef struct packed {
    logic shift;
    logic clear;
  } b58_ctl_t;

  // Alphabet lookup: valid=0 for codes outside the alphabet
  function automatic b58_lnk_t digit_of(input logic [7:0] c);
    b58_lnk_t r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c >= 8'h31 && c <= 8'h39) begin
      d = c - 8'h31; r.valid = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h48) begin
      d = c - 8'h41 + 8'd9; r.valid = 1'b1;
    end else if (c >= 8'h4A && c <= 8'h4E) begin
      d = c - 8'h4A + 8'd17; r.valid = 1'b1;
    end else if (c >= 8'h50 && c <= 8'h5A) begin
      d = c - 8'h50 + 8'd22; r.valid = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h6B) begin
      d = c - 8'h61 + 8'd33; r.valid = 1'b1;
    end else if (c >= 8'h6D && c <= 8'h7A) begin
      d = c - 8'h6D + 8'd44; r.valid = 1'b1;
    end
    r.carry = d[5:0];
    return r;
  endfunction

endpackage

>>> design/base58_string_decoder.sv
// Base58 string decoder: one character request accepted per cycle while a string is read.
// After the final character: carries drain, leading zero bytes are skipped, the check
// state runs, then one result per cycle while the consumer accepts; the
// next string is accepted once the last result is loaded. Carries move one byte per cycle.
// Reset (async, low) clears the accumulator, counters and flags; max_output_length is 25.
module base58_string_decoder import b58dec_pkg::*; #(
  parameter int unsigned ACC_BYTES = ACC_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input characters
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tlast,   // final_char
  // decoded bytes
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [1:0] status
  output logic       m_axis_tlast,   // last_of_run
  // configuration
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i     // max_output_length
);

  localparam int unsigned SKIP_W = $clog2(ACC_BYTES + 1);
  localparam int unsigned TOT_W  = $clog2(ONES_MAX + ACC_BYTES + 1);

  b58_state_e  state_q, state_d;
  b58_ctl_t    ctl;
  b58_lnk_t    inj_q, inj_d, dig;
  logic [7:0]  msb_byte;
  b58_lnk_t    msb_lnk;
  logic        chain_busy, busy;
  logic [6:0]  maxlen_q, limit;
  logic [6:0]  ones_q, ones_d;
  logic        past_q, past_d, inv_q, inv_d, ovf_q, ovf_d;
  logic [SKIP_W-1:0] skip_q, skip_d;
  logic [TOT_W-1:0]  total_q, total_d, emit_q, emit_d, total_c, payload;
  b58_status_e err;
  logic        accept, out_free, load;
  logic [7:0]  obyte_q, obyte_d;
  b58_status_e ostat_q, ostat_d;
  logic        olast_q, olast_d, ovalid_q;

  b58dec_chain #(.ACC_BYTES(ACC_BYTES)) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .inject_i   (inj_q),
    .msb_byte_o (msb_byte),
    .msb_lnk_o  (msb_lnk),
    .busy_o     (chain_busy)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign busy          = chain_busy || inj_q.valid;
  assign dig           = digit_of(s_axis_tdata);
  assign limit         = (maxlen_q > 7'(RESULT_CAP)) ? 7'(RESULT_CAP) : maxlen_q;
  assign out_free      = !ovalid_q || m_axis_tready;

  // Character intake: leading ones, alphabet check, digit injection
  always_comb begin
    inj_d  = '0;
    ones_d = ones_q;
    past_d = past_q;
    inv_d  = inv_q;
    ovf_d  = ovf_q;
    if (msb_lnk.valid && msb_lnk.carry != '0) begin
      ovf_d = 1'b1;
    end
    if (accept && !inv_q && !ovf_q) begin
      if (!past_q && s_axis_tdata == ONE_CHAR) begin
        if (ones_q != 7'(ONES_MAX)) ones_d = ones_q + 7'd1;
      end else begin
        past_d = 1'b1;
        if (dig.valid) inj_d = dig;
        else           inv_d = 1'b1;
      end
    end
    if (ctl.clear) begin
      ones_d = '0;
      past_d = 1'b0;
      inv_d  = 1'b0;
      ovf_d  = 1'b0;
    end
  end

  // Length and error resolution: overflow wins over invalid, invalid over too long
  always_comb begin
    payload = TOT_W'(ACC_BYTES) - TOT_W'(skip_q);
    total_c = TOT_W'(ones_q) + payload;
    if (ovf_q)                          err = STAT_OVERFLOW;
    else if (inv_q)                     err = STAT_INVALID;
    else if (total_c > TOT_W'(limit))   err = STAT_TOO_LONG;
    else                                err = STAT_OK;
  end

  // Sequencer: drain, skip zero bytes, check, emit
  always_comb begin
    state_d   = state_q;
    ctl       = '0;
    load      = 1'b0;
    obyte_d   = '0;
    ostat_d   = STAT_OK;
    olast_d   = 1'b0;
    skip_d    = skip_q;
    emit_d    = emit_q;
    total_d   = total_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && s_axis_tlast) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!busy) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (msb_byte != '0 || skip_q == SKIP_W'(ACC_BYTES)) begin
          state_d = ST_CHECK;
        end else begin
          ctl.shift = 1'b1;
          skip_d    = skip_q + 1'b1;
        end
      end
      ST_CHECK: begin
        total_d = total_c;
        if (err != STAT_OK || total_c == '0) begin
          if (out_free) begin
            load      = 1'b1;
            ostat_d   = err;
            olast_d   = 1'b1;
            ctl.clear = 1'b1;
            skip_d    = '0;
            state_d   = ST_IDLE;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          olast_d = (emit_q == total_q - 1'b1);
          if (emit_q >= TOT_W'(ones_q)) begin
            obyte_d   = msb_byte;
            ctl.shift = 1'b1;
          end
          emit_d = emit_q + 1'b1;
          if (olast_d) begin
            ctl.clear = 1'b1;
            skip_d    = '0;
            emit_d    = '0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      inj_q    <= '0;
      ones_q   <= '0;
      past_q   <= 1'b0;
      inv_q    <= 1'b0;
      ovf_q    <= 1'b0;
      skip_q   <= '0;
      emit_q   <= '0;
      total_q  <= '0;
      maxlen_q <= MAXLEN_RESET;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inj_q   <= inj_d;
      ones_q  <= ones_d;
      past_q  <= past_d;
      inv_q   <= inv_d;
      ovf_q   <= ovf_d;
      skip_q  <= skip_d;
      emit_q  <= emit_d;
      total_q <= total_d;
      if (cfg_we_i) maxlen_q <= cfg_wdata_i;
      if (out_free) ovalid_q <= load;
    end
  end

  // Output register, holds while the consumer stalls
  always_ff @(posedge clk_i) begin
    if (out_free && load) begin
      obyte_q <= obyte_d;
      ostat_q <= ostat_d;
      olast_q <= olast_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = obyte_q;
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tlast  = olast_q;

`include "base58_string_decoder_assert.svh"

  `B58_ASSERT_IMP(a_scan_drained, (state_q == ST_SCAN || state_q == ST_EMIT), !busy,
    "carry still in flight after drain")
  `B58_ASSERT_IMP(a_err_is_last, (m_axis_tvalid && m_axis_tuser != STAT_OK),
    m_axis_tlast, "error result without last flag")
  `B58_ASSERT_NXT(a_clear_state, ctl.clear,
    (ones_q == '0 && !inv_q && !ovf_q && msb_byte == '0), "state not cleared after string")
  `B58_ASSERT_IMP(a_idle_counters, s_axis_tready, (skip_q == '0 && emit_q == '0),
    "counters not reset in idle")

endmodule

>>> design/b58dec_cell.sv
// One accumulator byte: multiply-by-58 with carry from the less significant
// neighbor, shift in the neighbor's byte, or clear. Depends on b58dec_pkg.
module b58dec_cell import b58dec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  b58_ctl_t   ctl_i,
  input  b58_lnk_t   lnk_i,     // token from less significant neighbor
  input  logic [7:0] nb_byte_i, // neighbor byte for shifting
  output logic [7:0] byte_o,
  output b58_lnk_t   lnk_o      // token to more significant neighbor
);

  logic [7:0]  byte_q, byte_d;
  b58_lnk_t    lnk_q, lnk_d;
  logic [13:0] sum;

  // byte * 58 + carry; fits 14 bits, carry out below 58
  always_comb begin
    sum    = 14'(byte_q) * 14'(RADIX) + 14'(lnk_i.carry);
    byte_d = byte_q;
    lnk_d  = '0;
    if (ctl_i.clear) begin
      byte_d = '0;
    end else if (ctl_i.shift) begin
      byte_d = nb_byte_i;
    end else if (lnk_i.valid) begin
      byte_d      = sum[7:0];
      lnk_d.valid = 1'b1;
      lnk_d.carry = sum[13:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
      lnk_q  <= '0;
    end else begin
      byte_q <= byte_d;
      lnk_q  <= lnk_d;
    end
  end

  assign byte_o = byte_q;
  assign lnk_o  = lnk_q;

endmodule

>>> design/b58dec_chain.sv
// Row of accumulator cells, most significant byte at index 0.
// Carries move one cell per cycle toward index 0. Depends on b58dec_pkg, b58dec_cell.
module b58dec_chain import b58dec_pkg::*; #(
  parameter int unsigned ACC_BYTES = ACC_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  b58_ctl_t   ctl_i,
  input  b58_lnk_t   inject_i,   // digit entering the least significant cell
  output logic [7:0] msb_byte_o,
  output b58_lnk_t   msb_lnk_o,  // carry out of the most significant cell
  output logic       busy_o      // any token still in the row
);

  logic [7:0]           byte_w [ACC_BYTES];
  b58_lnk_t             lnk_w  [ACC_BYTES];
  logic [ACC_BYTES-1:0] tok_w;

  for (genvar k = 0; k < ACC_BYTES; k++) begin : g_cell
    b58_lnk_t   lnk_in;
    logic [7:0] nb_in;

    if (k == ACC_BYTES - 1) begin : g_lsb
      assign lnk_in = inject_i;
      assign nb_in  = '0;
    end else begin : g_mid
      assign lnk_in = lnk_w[k+1];
      assign nb_in  = byte_w[k+1];
    end

    b58dec_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl_i),
      .lnk_i     (lnk_in),
      .nb_byte_i (nb_in),
      .byte_o    (byte_w[k]),
      .lnk_o     (lnk_w[k])
    );

    assign tok_w[k] = lnk_w[k].valid;
  end

  assign msb_byte_o = byte_w[0];
  assign msb_lnk_o  = lnk_w[0];
  assign busy_o     = |tok_w;

endmodule
